>>> design/mms_pkg.sv
// Shared constants, status codes and types for the min/max stack.
package mms_pkg;

    localparam int STACK_DEPTH = 128;
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int COUNT_OUT_W = 8;

    typedef enum logic {
        ACT_PUSH = 1'b0,
        ACT_POP  = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    typedef logic signed [DATA_W-1:0] t_word;

endpackage

>>> design/mms_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module mms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/mms_scan.sv
// Running min/max accumulator fed one stored word per cycle during a rescan.
module mms_scan
    import mms_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_valid,
    input  logic  i_first,
    input  t_word i_data,
    output t_word o_max,
    output t_word o_min
);

    t_word r_max;
    t_word r_min;

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            // first word seeds both extremes
            if (i_first || (i_data > r_max)) begin
                r_max <= i_data;
            end
            if (i_first || (i_data < r_min)) begin
                r_min <= i_data;
            end
        end
    end

    assign o_max = r_max;
    assign o_min = r_min;

endmodule

>>> design/min_max_stack.sv
// Top level of the min/max stack: control sequencer, entry RAM and rescan unit.
//
// Usage
//   Command channel: drive i_action / i_push_value and raise start; the word
//   is taken at the rising edge where start is high and busy is low.
//   Result channel: one result word per command, shown for exactly one cycle
//   with o_valid high. The receiver cannot stall; it must take it then.
//
// Command timing (n = entries left after a pop)
//   Push (ok or overflow) and pop on an empty stack: result in the cycle
//   after acceptance, busy stays low, so one command per cycle.
//   Pop of an entry that is neither min nor max, or that empties the stack:
//   one RAM read, busy high for one cycle; the result is registered after the read wait state.
//   Pop of the current min or max: the remaining n entries are reread
//   through the single RAM read port, one per cycle, to rebuild both
//   extremes; that scan sets the worst case.
//
// Reset (i_rst_n low, synchronous): stack empty, min = max = 0, no result
//   pending. The entry RAM is not cleared; only written entries are read.
module min_max_stack
    import mms_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   i_action,
    input  logic signed [31:0]     i_push_value,
    output logic                   o_valid,
    output logic signed [31:0]     o_popped_value,
    output logic [1:0]             o_status,
    output logic [7:0]             o_entry_count,
    output logic signed [31:0]     o_largest,
    output logic signed [31:0]     o_smallest,
    output logic                   o_is_empty
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP_WAIT,
        S_SCAN
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    t_word            r_max, n_max;
    t_word            r_min, n_min;
    t_word            r_popped, n_popped;
    logic [CNT_W-1:0] r_scan_addr, n_scan_addr;
    logic             r_rd_pend, n_rd_pend;
    logic             r_rd_first, n_rd_first;
    logic             r_valid, n_valid;
    t_word            r_out_popped, n_out_popped;
    t_status          r_status, n_status;

    logic             accept;
    logic             is_full;
    logic [CNT_W-1:0] count_m1;
    logic             scan_issue;

    logic             ram_we;
    logic             ram_re;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr;
    t_word            ram_rdata;
    t_word            scan_max;
    t_word            scan_min;

    assign accept     = start && (r_state == S_IDLE);
    assign is_full    = (r_count == CNT_W'(STACK_DEPTH));
    assign count_m1   = r_count - 1'b1;
    assign scan_issue = (r_state == S_SCAN) && (r_scan_addr < r_count);

    // Push writes the top slot at acceptance; nothing else writes the RAM.
    assign ram_we    = accept && (t_action'(i_action) == ACT_PUSH) && !is_full;
    assign ram_waddr = r_count[ADDR_W-1:0];

    // Pop reads the top slot at acceptance; the scan reads bottom-up.
    assign ram_re    = (accept && (t_action'(i_action) == ACT_POP) && (r_count != '0))
                       || scan_issue;
    assign ram_raddr = (r_state == S_IDLE) ? count_m1[ADDR_W-1:0]
                                           : r_scan_addr[ADDR_W-1:0];

    mms_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_push_value),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    mms_scan u_scan (
        .i_clk   (i_clk),
        .i_valid (r_rd_pend),
        .i_first (r_rd_first),
        .i_data  (ram_rdata),
        .o_max   (scan_max),
        .o_min   (scan_min)
    );

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_max        = r_max;
        n_min        = r_min;
        n_popped     = r_popped;
        n_scan_addr  = r_scan_addr;
        n_rd_pend    = scan_issue;
        n_rd_first   = scan_issue && (r_scan_addr == '0);
        n_valid      = 1'b0;
        n_out_popped = r_out_popped;
        n_status     = r_status;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (t_action'(i_action) == ACT_PUSH) begin
                        n_valid      = 1'b1;
                        n_out_popped = '0;
                        if (is_full) begin
                            n_status = ST_OVERFLOW;
                        end else begin
                            n_status = ST_OK;
                            n_count  = r_count + 1'b1;
                            // each extreme moves on its own
                            if ((r_count == '0) || (i_push_value > r_max)) begin
                                n_max = i_push_value;
                            end
                            if ((r_count == '0) || (i_push_value < r_min)) begin
                                n_min = i_push_value;
                            end
                        end
                    end else if (r_count == '0) begin
                        n_valid      = 1'b1;
                        n_status     = ST_UNDERFLOW;
                        n_out_popped = '1;
                    end else begin
                        n_count = count_m1;
                        n_state = S_POP_WAIT;
                    end
                end
            end
            S_POP_WAIT: begin
                // ram_rdata holds the popped top word; r_count already decremented
                n_popped = ram_rdata;
                if (r_count == '0) begin
                    n_max        = '0;
                    n_min        = '0;
                    n_valid      = 1'b1;
                    n_status     = ST_OK;
                    n_out_popped = ram_rdata;
                    n_state      = S_IDLE;
                end else if ((ram_rdata == r_max) || (ram_rdata == r_min)) begin
                    n_scan_addr = '0;
                    n_state     = S_SCAN;
                end else begin
                    n_valid      = 1'b1;
                    n_status     = ST_OK;
                    n_out_popped = ram_rdata;
                    n_state      = S_IDLE;
                end
            end
            S_SCAN: begin
                if (scan_issue) begin
                    n_scan_addr = r_scan_addr + 1'b1;
                end else if (!r_rd_pend) begin
                    // last word has landed in the scan unit
                    n_max        = scan_max;
                    n_min        = scan_min;
                    n_valid      = 1'b1;
                    n_status     = ST_OK;
                    n_out_popped = r_popped;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_max       <= '0;
            r_min       <= '0;
            r_scan_addr <= '0;
            r_rd_pend   <= 1'b0;
            r_rd_first  <= 1'b0;
            r_valid     <= 1'b0;
            r_status    <= ST_OK;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_max       <= n_max;
            r_min       <= n_min;
            r_scan_addr <= n_scan_addr;
            r_rd_pend   <= n_rd_pend;
            r_rd_first  <= n_rd_first;
            r_valid     <= n_valid;
            r_status    <= n_status;
        end
        r_popped     <= n_popped;
        r_out_popped <= n_out_popped;
    end

    // Count and extremes are already updated when the strobe rises.
    assign busy           = (r_state != S_IDLE);
    assign o_valid        = r_valid;
    assign o_popped_value = r_out_popped;
    assign o_status       = r_status;
    assign o_entry_count  = COUNT_OUT_W'(r_count);
    assign o_largest      = r_max;
    assign o_smallest     = r_min;
    assign o_is_empty     = (r_count == '0);

    // A pop on a non-empty stack must occupy the sequencer.
    a_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_action == ACT_POP) && (r_count != '0)) |=> busy && !o_valid)
        else $error("pop did not enter read wait");

    // Empty stack reports zero extremes.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_count == '0)) |-> ((r_max == '0) && (r_min == '0)))
        else $error("empty stack with nonzero extremes");

    // Overflow only when full.
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_status == ST_OVERFLOW)) |-> is_full)
        else $error("overflow reported while not full");

    // Scan never reads beyond the held entries.
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_scan_addr <= r_count))
        else $error("scan address past top");

    // Held extremes stay ordered.
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_min <= r_max))
        else $error("min above max");

endmodule

>>> bench/testbench.sv
// Self-checking bench for min_max_stack: directed table, then random push/pop traffic.
`timescale 1ns / 100ps

module testbench
    import mms_pkg::*;
();

    // Longest stretch with no word taken on either side: a full rescan
    // plus a sender gap, taken several times over.
    localparam int STALL_LIMIT  = 8 * (STACK_DEPTH + 8);
    localparam int RANDOM_WORDS = 1100;
    localparam int EPISODE_LEN  = 220;

    localparam t_word W_MIN = 32'sh8000_0000;
    localparam t_word W_MAX = 32'sh7FFF_FFFF;

    // One result word as the block shows it.
    typedef struct packed {
        t_word      popped;
        t_status    status;
        logic [7:0] count;
        t_word      largest;
        t_word      smallest;
        logic       empty;
    } t_stack_view;

    // One directed command; when typed is set the expected word is the one
    // written in the row, otherwise the bench model decides it.
    typedef struct packed {
        t_action     act;
        t_word       value;
        bit          typed;
        t_stack_view view;
    } t_stim_row;

    localparam t_stack_view NO_VIEW = '{32'sd0, ST_OK, 8'd0, 32'sd0, 32'sd0, 1'b0};

    localparam t_stim_row DIRECTED [21] = '{
        // pop right after reset: underflow, -1 returned, still empty
        '{ACT_POP,  32'sd0, 1'b1, '{-32'sd1, ST_UNDERFLOW, 8'd0, 32'sd0, 32'sd0, 1'b1}},
        // first push sets both extremes
        '{ACT_PUSH, W_MIN,  1'b1, '{32'sd0, ST_OK, 8'd1, W_MIN, W_MIN, 1'b0}},
        '{ACT_PUSH, W_MAX,  1'b1, '{32'sd0, ST_OK, 8'd2, W_MAX, W_MIN, 1'b0}},
        '{ACT_PUSH, 32'sd0, 1'b1, '{32'sd0, ST_OK, 8'd3, W_MAX, W_MIN, 1'b0}},
        // pop of a middle value leaves extremes alone (push value ignored)
        '{ACT_POP,  W_MAX,  1'b1, '{32'sd0, ST_OK, 8'd2, W_MAX, W_MIN, 1'b0}},
        // pop of the max forces a rescan
        '{ACT_POP,  -32'sd1, 1'b1, '{W_MAX, ST_OK, 8'd1, W_MIN, W_MIN, 1'b0}},
        // pop that empties: extremes read zero
        '{ACT_POP,  32'sd0, 1'b1, '{W_MIN, ST_OK, 8'd0, 32'sd0, 32'sd0, 1'b1}},
        '{ACT_POP,  W_MIN,  1'b1, '{-32'sd1, ST_UNDERFLOW, 8'd0, 32'sd0, 32'sd0, 1'b1}},
        // duplicates of an extreme, then pops of min and of a duplicated max
        '{ACT_PUSH, -32'sd1, 1'b0, NO_VIEW},
        '{ACT_PUSH, 32'sd5,  1'b0, NO_VIEW},
        '{ACT_PUSH, 32'sd5,  1'b0, NO_VIEW},
        '{ACT_PUSH, -32'sd7, 1'b0, NO_VIEW},
        '{ACT_POP,  32'sd3,  1'b0, NO_VIEW},
        '{ACT_POP,  32'sd9,  1'b0, NO_VIEW},
        // alternating bit patterns on the data path
        '{ACT_PUSH, 32'sh5555_5555, 1'b0, NO_VIEW},
        '{ACT_PUSH, 32'shAAAA_AAAA, 1'b0, NO_VIEW},
        '{ACT_POP,  32'shAAAA_AAAA, 1'b0, NO_VIEW},
        '{ACT_POP,  32'sh5555_5555, 1'b0, NO_VIEW},
        '{ACT_POP,  32'sd0, 1'b0, NO_VIEW},
        '{ACT_POP,  32'sd0, 1'b0, NO_VIEW},
        '{ACT_POP,  32'sd0, 1'b0, NO_VIEW}
    };

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic              i_action;
    logic signed [31:0] i_push_value;
    logic              o_valid;
    logic signed [31:0] o_popped_value;
    logic [1:0]        o_status;
    logic [7:0]        o_entry_count;
    logic signed [31:0] o_largest;
    logic signed [31:0] o_smallest;
    logic              o_is_empty;

    // Bench copy of the stack contents and extremes.
    t_word shadow_entries [STACK_DEPTH];
    int    shadow_count;
    t_word shadow_max;
    t_word shadow_min;

    t_stack_view pending_views [$];
    int          mismatch_count;
    int          quiet_cycles;

    min_max_stack dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_push_value   (i_push_value),
        .o_valid        (o_valid),
        .o_popped_value (o_popped_value),
        .o_status       (o_status),
        .o_entry_count  (o_entry_count),
        .o_largest      (o_largest),
        .o_smallest     (o_smallest),
        .o_is_empty     (o_is_empty)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Applies one command to the bench stack and returns the word it yields.
    function automatic t_stack_view apply_stack_op(input t_action act, input t_word value);
        t_stack_view view;
        t_word       top;
        int          i;
        view.popped = '0;
        view.status = ST_OK;
        if (act == ACT_PUSH) begin
            if (shadow_count >= STACK_DEPTH) begin
                view.status = ST_OVERFLOW;
            end else begin
                shadow_entries[shadow_count] = value;
                if (shadow_count == 0) begin
                    shadow_max = value;
                    shadow_min = value;
                end else begin
                    if (value > shadow_max) shadow_max = value;
                    if (value < shadow_min) shadow_min = value;
                end
                shadow_count++;
            end
        end else if (shadow_count == 0) begin
            view.status = ST_UNDERFLOW;
            view.popped = -32'sd1;
        end else begin
            shadow_count--;
            top = shadow_entries[shadow_count];
            view.popped = top;
            if (shadow_count == 0) begin
                shadow_max = '0;
                shadow_min = '0;
            end else if (top == shadow_max || top == shadow_min) begin
                // an extreme left: rebuild both from what is still held
                shadow_max = shadow_entries[0];
                shadow_min = shadow_entries[0];
                for (i = 1; i < shadow_count; i++) begin
                    if (shadow_entries[i] > shadow_max) shadow_max = shadow_entries[i];
                    if (shadow_entries[i] < shadow_min) shadow_min = shadow_entries[i];
                end
            end
        end
        view.count    = shadow_count[7:0];
        view.largest  = shadow_max;
        view.smallest = shadow_min;
        view.empty    = (shadow_count == 0);
        return view;
    endfunction

    // Presents one command word and holds it until the block takes it.
    task automatic send_word(input t_action act, input t_word value, input bit typed,
                             input t_stack_view typed_view);
        t_stack_view model_view;
        start        <= 1'b1;
        i_action     <= act;
        i_push_value <= value;
        do @(posedge i_clk); while (busy !== 1'b0);
        // taken at this edge: the bench stack moves with the block
        model_view = apply_stack_op(act, value);
        pending_views.push_back(typed ? typed_view : model_view);
    endtask

    // Random sender gap, with junk on the data lines.
    task automatic maybe_pause(input bit allowed);
        if (allowed && $urandom_range(99) < 38) begin
            start        <= 1'b0;
            i_action     <= 1'($urandom);
            i_push_value <= $urandom;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    task automatic report_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h, got %h", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    // Result side: one word per strobe, compared against the oldest expectation.
    always @(posedge i_clk) begin
        t_stack_view want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            if (pending_views.size() == 0) begin
                $display("%0t: result word with nothing expected, popped %h",
                         $time, o_popped_value);
                mismatch_count++;
            end else begin
                want = pending_views.pop_front();
                report_field("popped_value", want.popped,   o_popped_value);
                report_field("status",       want.status,   o_status);
                report_field("entry_count",  want.count,    o_entry_count);
                report_field("largest",      want.largest,  o_largest);
                report_field("smallest",     want.smallest, o_smallest);
                report_field("is_empty",     want.empty,    o_is_empty);
            end
        end
    end

    // Watchdog: ends the run if neither side moves a word for too long.
    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_valid === 1'b1)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int      n;
        int      push_pct;
        bit      no_gaps;
        t_action act;
        t_word   value;

        mismatch_count = 0;
        quiet_cycles   = 0;
        shadow_count   = 0;
        shadow_max     = '0;
        shadow_min     = '0;
        start        <= 1'b0;
        i_action     <= 1'b0;
        i_push_value <= '0;
        i_rst_n      <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[k]) begin
            maybe_pause(1'b1);
            send_word(DIRECTED[k].act, DIRECTED[k].value, DIRECTED[k].typed,
                      DIRECTED[k].view);
        end

        // Random traffic in episodes: fill (runs into overflow), drain (runs
        // into underflow), then a balanced mix that pops extremes often.
        for (n = 0; n < RANDOM_WORDS; n++) begin
            case ((n / EPISODE_LEN) % 3)
                0:       push_pct = 85;
                1:       push_pct = 15;
                default: push_pct = 50;
            endcase
            // one whole episode runs back to back with no sender gaps
            no_gaps = (n >= 2 * EPISODE_LEN && n < 3 * EPISODE_LEN);
            maybe_pause(!no_gaps);
            act = ($urandom_range(99) < push_pct) ? ACT_PUSH : ACT_POP;
            // lean on the extremes and a narrow band so duplicates are common
            case ($urandom_range(7))
                0:       value = W_MIN;
                1:       value = W_MAX;
                2, 3:    value = $urandom_range(16) - 8;
                default: value = $urandom;
            endcase
            send_word(act, value, 1'b0, NO_VIEW);
        end
        start <= 1'b0;

        while (pending_views.size() != 0) @(posedge i_clk);
        // room for a stray word after the last expected one
        repeat (STACK_DEPTH + 4) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> filelist.f
design/mms_pkg.sv
design/mms_ram.sv
design/mms_scan.sv
design/min_max_stack.sv
bench/testbench.sv
